// File: hw/rtl/calendar_date_counter_unit_macros.svh
// Assertion macros for the calendar date counter.
// Included by the top level; expects a clock named clk and a reset named rst.
`ifndef CALENDAR_DATE_COUNTER_UNIT_MACROS_SVH
`define CALENDAR_DATE_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/cdc_pkg.sv
// Package for the calendar date counter: op codes, sequencer states,
// month length and leap year helpers. No dependencies.
`default_nettype none

package cdc_pkg;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_CHECK   = 3'd1;
  localparam logic [2:0] OP_INC     = 3'd2;
  localparam logic [2:0] OP_DEC     = 3'd3;
  localparam logic [2:0] OP_ADVANCE = 3'd4;

  localparam logic [4:0]  RST_DAY   = 5'd1;
  localparam logic [3:0]  RST_MONTH = 4'd1;
  localparam logic [15:0] RST_YEAR  = 16'd2000;
  localparam logic        RST_LEAP  = 1'b1;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAYS_LONG = 5'd31;

  // x divisible by 25 iff (x * inverse of 25 mod 2^16) mod 2^16 <= floor((2^16-1)/25)
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_LIM = 16'd2621;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP_IN,
    ST_CHECK,
    ST_STEP,
    ST_RELEAP,
    ST_DONE
  } state_t;

  function automatic logic leap_year(input logic [15:0] y);
    logic [31:0] prod;
    logic        div25;
    prod  = 32'(y) * 32'(INV25);
    div25 = (prod[15:0] <= DIV25_LIM);
    // divisible by 4 and not 100, or by 400 (= 16 and 25)
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MONTH_FEB:                        len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:          len = 5'd30;
      default:                          len = DAYS_LONG;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/calendar_date_counter_unit.sv
// Gregorian calendar date counter: sequencer, date registers and shared leap unit.
// Depends on cdc_pkg and calendar_date_counter_unit_macros.svh.
//
// Usage:
//   Input channel in_valid/in_stall carries op, in_day, in_month, in_year,
//   step_count; a beat is taken when in_valid is high and in_stall low.
//   Output channel out_valid/out_stall carries out_day, out_month, out_year,
//   date_valid; one result beat for every input beat, in order.
//   One item is in work at a time; in_stall is high from acceptance until the
//   result is written to the output register. The output register lets the
//   next beat be accepted while a result still waits downstream.
//   Load and check pass ST_LEAP_IN, ST_CHECK and ST_DONE; increment and
//   decrement take one ST_STEP, plus ST_RELEAP when the year rolls over;
//   advance by n takes n ST_STEP, plus one ST_RELEAP per year boundary
//   crossed; advance by zero goes straight to ST_DONE. in_stall drops in
//   the same cycle that out_valid is loaded. The single day-step unit handles
//   one day per cycle, but after each year change it waits in ST_RELEAP on the
//   shared leap unit (one 16-bit multiply by the inverse of 25).
//   If out_stall holds a result, a finished item waits in its last state.
//   Reset (rst, synchronous) stores 1 January 2000 and empties the output.
`default_nettype none
`include "calendar_date_counter_unit_macros.svh"

module calendar_date_counter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  op,
  input  wire logic [4:0]  in_day,
  input  wire logic [3:0]  in_month,
  input  wire logic [15:0] in_year,
  input  wire logic [15:0] step_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_day,
  output logic [3:0]       out_month,
  output logic [15:0]      out_year,
  output logic             date_valid
);

  cdc_pkg::state_t state, state_next;

  logic [2:0]  op_q;
  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [15:0] year_q;
  logic [15:0] count, count_next;
  logic        valid_q, valid_q_next;
  logic        leap_q;

  logic [4:0]  cur_day, cur_day_next;
  logic [3:0]  cur_month, cur_month_next;
  logic [15:0] cur_year, cur_year_next;
  logic        cur_leap, cur_leap_next;

  logic        out_valid_next;
  logic        accept;
  logic        emit;
  logic [15:0] leap_year_sel;
  logic        leap_res;
  logic        in_date_ok;
  logic        year_chg;
  logic [15:0] count_dec;
  logic [3:0]  month_prev;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != cdc_pkg::ST_IDLE);
  assign emit      = (state == cdc_pkg::ST_DONE) && (!out_valid || !out_stall);
  assign count_dec = count - 16'd1;
  assign month_prev = cur_month - 4'd1;

  // shared leap unit
  assign leap_year_sel = (state == cdc_pkg::ST_LEAP_IN) ? year_q : cur_year;
  assign leap_res      = cdc_pkg::leap_year(leap_year_sel);

  assign in_date_ok = (month_q inside {[4'd1:4'd12]}) && (day_q != 5'd0) &&
                      (day_q <= cdc_pkg::month_len(month_q, leap_q));

  always_comb begin
    state_next     = state;
    count_next     = count;
    valid_q_next   = valid_q;
    cur_day_next   = cur_day;
    cur_month_next = cur_month;
    cur_year_next  = cur_year;
    cur_leap_next  = cur_leap;
    year_chg       = 1'b0;
    out_valid_next = out_valid && out_stall;

    case (state)
      cdc_pkg::ST_IDLE: begin
        if (accept) begin
          valid_q_next = 1'b1;
          count_next   = (op == cdc_pkg::OP_ADVANCE) ? step_count : 16'd1;
          case (op)
            cdc_pkg::OP_LOAD, cdc_pkg::OP_CHECK: state_next = cdc_pkg::ST_LEAP_IN;
            cdc_pkg::OP_INC, cdc_pkg::OP_DEC:    state_next = cdc_pkg::ST_STEP;
            cdc_pkg::OP_ADVANCE: begin
              state_next = (step_count == 16'd0) ? cdc_pkg::ST_DONE : cdc_pkg::ST_STEP;
            end
            default:                             state_next = cdc_pkg::ST_DONE;
          endcase
        end
      end
      cdc_pkg::ST_LEAP_IN: begin
        state_next = cdc_pkg::ST_CHECK;
      end
      cdc_pkg::ST_CHECK: begin
        valid_q_next = in_date_ok;
        if (in_date_ok && (op_q == cdc_pkg::OP_LOAD)) begin
          cur_day_next   = day_q;
          cur_month_next = month_q;
          cur_year_next  = year_q;
          cur_leap_next  = leap_q;
        end
        state_next = cdc_pkg::ST_DONE;
      end
      cdc_pkg::ST_STEP: begin
        if (op_q == cdc_pkg::OP_DEC) begin
          if (cur_day > 5'd1) begin
            cur_day_next = cur_day - 5'd1;
          end else if (cur_month > 4'd1) begin
            cur_month_next = month_prev;
            cur_day_next   = cdc_pkg::month_len(month_prev, cur_leap);
          end else begin
            cur_month_next = cdc_pkg::MONTH_DEC;
            cur_day_next   = cdc_pkg::DAYS_LONG;
            cur_year_next  = cur_year - 16'd1;
            year_chg       = 1'b1;
          end
        end else begin
          if (cur_day < cdc_pkg::month_len(cur_month, cur_leap)) begin
            cur_day_next = cur_day + 5'd1;
          end else begin
            cur_day_next = 5'd1;
            if (cur_month < cdc_pkg::MONTH_DEC) begin
              cur_month_next = cur_month + 4'd1;
            end else begin
              cur_month_next = 4'd1;
              cur_year_next  = cur_year + 16'd1;
              year_chg       = 1'b1;
            end
          end
        end
        count_next = count_dec;
        if (year_chg) begin
          state_next = cdc_pkg::ST_RELEAP;
        end else if (count_dec != 16'd0) begin
          state_next = cdc_pkg::ST_STEP;
        end else begin
          state_next = cdc_pkg::ST_DONE;
        end
      end
      cdc_pkg::ST_RELEAP: begin
        cur_leap_next = leap_res;
        state_next    = (count != 16'd0) ? cdc_pkg::ST_STEP : cdc_pkg::ST_DONE;
      end
      cdc_pkg::ST_DONE: begin
        if (emit) begin
          out_valid_next = 1'b1;
          state_next     = cdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cdc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cdc_pkg::ST_IDLE;
      out_valid <= 1'b0;
      cur_day   <= cdc_pkg::RST_DAY;
      cur_month <= cdc_pkg::RST_MONTH;
      cur_year  <= cdc_pkg::RST_YEAR;
      cur_leap  <= cdc_pkg::RST_LEAP;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cur_day   <= cur_day_next;
      cur_month <= cur_month_next;
      cur_year  <= cur_year_next;
      cur_leap  <= cur_leap_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      day_q   <= in_day;
      month_q <= in_month;
      year_q  <= in_year;
    end
    count   <= count_next;
    valid_q <= valid_q_next;
    leap_q  <= leap_res;
    if (emit) begin
      out_day    <= cur_day;
      out_month  <= cur_month;
      out_year   <= cur_year;
      date_valid <= valid_q;
    end
  end

  // stored date is always a real date
  `CDC_ASSERT_NOW(a_cur_date_sane, 1'b1,
    (cur_month >= 4'd1) && (cur_month <= 4'd12) && (cur_day >= 5'd1) &&
    (cur_day <= cdc_pkg::month_len(cur_month, cur_leap)), "stored date out of range")
  // leap flag tracks the stored year whenever idle
  `CDC_ASSERT_NOW(a_leap_tracks, state == cdc_pkg::ST_IDLE,
    cur_leap == cdc_pkg::leap_year(cur_year), "leap flag stale")
  // advance by zero goes straight to the result
  `CDC_ASSERT_NEXT(a_adv_zero, accept && (op == cdc_pkg::OP_ADVANCE) && (step_count == 16'd0),
    state == cdc_pkg::ST_DONE, "advance by zero did not finish at once")

endmodule

`default_nettype wire

// File: tb/tb_calendar_date_counter_unit.sv
// Self-checking testbench for calendar_date_counter_unit: queue-fed driver, clocked
// monitor and a Gregorian date predictor kept in step with the accepted beats.
// Depends on cdc_pkg and the calendar_date_counter_unit RTL.
`timescale 1ns / 100ps

module tb_calendar_date_counter_unit;

  // op codes with no defined function; the block must leave the date alone
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [15:0] count;
  } date_cmd_t;

  typedef struct {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        ok;
  } date_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  op = cdc_pkg::OP_LOAD;
  logic [4:0]  in_day = '0;
  logic [3:0]  in_month = '0;
  logic [15:0] in_year = '0;
  logic [15:0] step_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [15:0] out_year;
  logic        date_valid;

  date_cmd_t pend_q[$];
  date_res_t dates_due_q[$];
  date_cmd_t on_bus;

  // predicted stored date
  logic [4:0]  st_day = cdc_pkg::RST_DAY;
  logic [3:0]  st_month = cdc_pkg::RST_MONTH;
  logic [15:0] st_year = cdc_pkg::RST_YEAR;

  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int err_count = 0;

  calendar_date_counter_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .in_day     (in_day),
    .in_month   (in_month),
    .in_year    (in_year),
    .step_count (step_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_day    (out_day),
    .out_month  (out_month),
    .out_year   (out_year),
    .date_valid (date_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic is_leap(logic [15:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [4:0] mon_days(logic [3:0] m, logic [15:0] y);
    logic [4:0] len;
    case (m)
      cdc_pkg::MONTH_FEB:      len = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic date_fits(logic [4:0] d, logic [3:0] m, logic [15:0] y);
    if (m < 4'd1 || m > cdc_pkg::MONTH_DEC) return 1'b0;
    return (d >= 5'd1) && (d <= mon_days(m, y));
  endfunction

  function automatic void day_fwd();
    if (st_day < mon_days(st_month, st_year)) begin
      st_day = st_day + 5'd1;
    end else begin
      st_day = 5'd1;
      if (st_month < cdc_pkg::MONTH_DEC) begin
        st_month = st_month + 4'd1;
      end else begin
        st_month = 4'd1;
        st_year = st_year + 16'd1;
      end
    end
  endfunction

  function automatic void day_back();
    if (st_day > 5'd1) begin
      st_day = st_day - 5'd1;
    end else begin
      if (st_month > 4'd1) begin
        st_month = st_month - 4'd1;
      end else begin
        st_month = cdc_pkg::MONTH_DEC;
        st_year = st_year - 16'd1;
      end
      st_day = mon_days(st_month, st_year);
    end
  endfunction

  function automatic date_res_t apply_cmd(date_cmd_t c);
    date_res_t r;
    int unsigned k;
    r.ok = 1'b1;
    case (c.op)
      cdc_pkg::OP_LOAD: begin
        if (date_fits(c.day, c.month, c.year)) begin
          st_day = c.day;
          st_month = c.month;
          st_year = c.year;
        end else begin
          r.ok = 1'b0;
        end
      end
      cdc_pkg::OP_CHECK:   r.ok = date_fits(c.day, c.month, c.year);
      cdc_pkg::OP_INC:     day_fwd();
      cdc_pkg::OP_DEC:     day_back();
      cdc_pkg::OP_ADVANCE: for (k = 0; k < c.count; k++) day_fwd();
      default: ;
    endcase
    r.day = st_day;
    r.month = st_month;
    r.year = st_year;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic add_cmd(logic [2:0] o, logic [4:0] d, logic [3:0] m, logic [15:0] y,
                         logic [15:0] n);
    date_cmd_t c;
    c.op = o;
    c.day = d;
    c.month = m;
    c.year = y;
    c.count = n;
    pend_q.push_back(c);
    n_queued++;
  endtask

  function automatic logic [15:0] pick_year();
    logic [15:0] y;
    case ($urandom_range(9))
      0:       y = 16'd0;
      1:       y = 16'hFFFF;
      2:       y = 16'(100 * $urandom_range(655));
      3:       y = 16'(400 * $urandom_range(163));
      4:       y = 16'(4 * $urandom_range(16383));
      5:       y = 16'(1890 + $urandom_range(530));
      default: y = 16'($urandom);
    endcase
    return y;
  endfunction

  // mostly short advances, now and then a long one
  function automatic logic [15:0] pick_count();
    logic [15:0] n;
    int sel;
    sel = $urandom_range(99);
    if (sel < 85) n = 16'($urandom_range(40));
    else if (sel < 98) n = 16'($urandom_range(1000));
    else n = 16'($urandom);
    return n;
  endfunction

  function automatic logic [2:0] pick_move();
    logic [2:0] o;
    case ($urandom_range(2))
      0:       o = cdc_pkg::OP_INC;
      1:       o = cdc_pkg::OP_DEC;
      default: o = cdc_pkg::OP_ADVANCE;
    endcase
    return o;
  endfunction

  task automatic add_random(int want);
    int made;
    int kind;
    int j;
    int len;
    logic [15:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    made = 0;
    while (made < want) begin
      kind = $urandom_range(99);
      y = pick_year();
      m = 4'($urandom_range(12, 1));
      if (kind < 40) begin
        // valid load, mostly near a month edge, then a few moves
        case ($urandom_range(3))
          0:       d = 5'd1;
          1:       d = mon_days(m, y);
          2:       d = mon_days(m, y) - 5'($urandom_range(2));
          default: d = 5'($urandom_range(mon_days(m, y), 1));
        endcase
        add_cmd(cdc_pkg::OP_LOAD, d, m, y, 16'($urandom));
        len = $urandom_range(4, 1);
        for (j = 0; j < len; j++) begin
          add_cmd(pick_move(), 5'($urandom), 4'($urandom), 16'($urandom), pick_count());
        end
        made += len + 1;
      end else if (kind < 65) begin
        // anything the fields allow
        add_cmd($urandom_range(1) ? cdc_pkg::OP_LOAD : cdc_pkg::OP_CHECK,
                5'($urandom_range(31)), 4'($urandom_range(15)), 16'($urandom),
                16'($urandom));
        made++;
      end else if (kind < 90) begin
        len = $urandom_range(6, 1);
        for (j = 0; j < len; j++) begin
          add_cmd(pick_move(), 5'($urandom), 4'($urandom), 16'($urandom), pick_count());
        end
        made += len;
      end else begin
        // just out of range dates and spare op codes
        case ($urandom_range(3))
          0: add_cmd(cdc_pkg::OP_LOAD, mon_days(m, y) + 5'd1, m, y, 16'($urandom));
          1: add_cmd(cdc_pkg::OP_CHECK, 5'd29, cdc_pkg::MONTH_FEB, y, 16'($urandom));
          2: add_cmd(cdc_pkg::OP_LOAD, 5'($urandom_range(31)), 4'($urandom_range(15, 13)),
                     y, 16'($urandom));
          default: add_cmd(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), 5'($urandom),
                           4'($urandom), 16'($urandom), 16'($urandom));
        endcase
        made++;
      end
    end
  endtask

  // every queued beat taken and every predicted result seen
  task automatic wait_drained();
    while (n_accepted != n_queued || dates_due_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    add_cmd(cdc_pkg::OP_INC, 5'd0, 4'd0, 16'd0, 16'd0);
    add_cmd(cdc_pkg::OP_DEC, 5'd0, 4'd0, 16'd0, 16'd0);
    add_cmd(cdc_pkg::OP_DEC, 5'd31, 4'd15, 16'hFFFF, 16'hFFFF);
    add_cmd(cdc_pkg::OP_LOAD, 5'd31, cdc_pkg::MONTH_DEC, 16'hFFFF, 16'd0);
    add_cmd(cdc_pkg::OP_INC, 5'd0, 4'd0, 16'd0, 16'd0);
    add_cmd(cdc_pkg::OP_DEC, 5'd0, 4'd0, 16'd0, 16'd0);
    add_cmd(cdc_pkg::OP_LOAD, 5'd29, cdc_pkg::MONTH_FEB, 16'd1900, 16'd0);
    add_cmd(cdc_pkg::OP_CHECK, 5'd29, cdc_pkg::MONTH_FEB, 16'd2000, 16'd0);
    add_cmd(cdc_pkg::OP_CHECK, 5'd29, cdc_pkg::MONTH_FEB, 16'd2100, 16'd0);
    add_cmd(cdc_pkg::OP_LOAD, 5'd29, cdc_pkg::MONTH_FEB, 16'd0, 16'd0);
    add_cmd(cdc_pkg::OP_INC, 5'd0, 4'd0, 16'd0, 16'd0);
    add_cmd(cdc_pkg::OP_DEC, 5'd0, 4'd0, 16'd0, 16'd0);
    add_cmd(cdc_pkg::OP_LOAD, 5'd0, 4'd6, 16'd2010, 16'd0);
    add_cmd(cdc_pkg::OP_CHECK, 5'd15, 4'd0, 16'd2010, 16'd0);
    add_cmd(cdc_pkg::OP_CHECK, 5'd31, 4'd15, 16'hFFFF, 16'd0);
    add_cmd(cdc_pkg::OP_CHECK, 5'd31, 4'd4, 16'd2022, 16'd0);
    add_cmd(cdc_pkg::OP_LOAD, 5'd28, cdc_pkg::MONTH_FEB, 16'd2023, 16'd0);
    add_cmd(cdc_pkg::OP_INC, 5'd0, 4'd0, 16'd0, 16'd0);
    add_cmd(cdc_pkg::OP_ADVANCE, 5'd31, 4'd15, 16'hFFFF, 16'd0);
    add_cmd(cdc_pkg::OP_ADVANCE, 5'd0, 4'd0, 16'd0, 16'hFFFF);
    add_cmd(OP_SPARE_LO, 5'd31, 4'd15, 16'hFFFF, 16'hFFFF);
    add_cmd(OP_SPARE_LO + 3'd1, 5'd3, 4'd3, 16'd3, 16'd3);
    add_cmd(OP_SPARE_HI, 5'd0, 4'd0, 16'd0, 16'd0);
    add_cmd(cdc_pkg::OP_LOAD, 5'd31, cdc_pkg::MONTH_DEC, 16'd2024, 16'd0);
    add_cmd(cdc_pkg::OP_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd1);
    wait_drained();
    add_random(250);
    // hold the sender until the block has emptied out
    wait_drained();
    add_random(250);
    wait_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drv
    logic took;
    logic idle;
    took = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        dates_due_q.push_back(apply_cmd(on_bus));
        n_accepted++;
        took = 1'b1;
      end
      if (!in_valid || took) begin
        idle = (n_accepted >= 150 && n_accepted < 260) ? 1'b0 : ($urandom_range(99) < 21);
        if (pend_q.size() != 0 && !idle) begin
          on_bus = pend_q.pop_front();
          op <= on_bus.op;
          in_day <= on_bus.day;
          in_month <= on_bus.month;
          in_year <= on_bus.year;
          step_count <= on_bus.count;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic log_fail(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : mon
    date_res_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (dates_due_q.size() == 0) begin
          log_fail($sformatf("unexpected result beat %0d/%0d/%0d valid %b",
                             out_day, out_month, out_year, date_valid));
        end else begin
          want = dates_due_q.pop_front();
          if (out_day !== want.day || out_month !== want.month ||
              out_year !== want.year || date_valid !== want.ok) begin
            log_fail($sformatf(
                "result %0d: expected %0d/%0d/%0d valid %b, got %0d/%0d/%0d valid %b",
                n_results, want.day, want.month, want.year, want.ok,
                out_day, out_month, out_year, date_valid));
          end
        end
      end
      out_stall <= (n_results >= 150 && n_results < 260) ? 1'b0 : ($urandom_range(99) < 21);
    end
  end

endmodule
